@@ sv/csvc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and constants for the cel-shade vertex coordinate core.
// No dependencies; every other file refers to this package by scoped names.
package csvc_pkg;

    localparam int FRAC_BITS = 14;
    localparam int LANE_W    = 16;
    localparam int CFG_W     = 3 * LANE_W;
    localparam int CFG_IDX_W = 2;

    // Rotated component: three 16x16 products summed.
    localparam int ROT_W    = 2 * LANE_W + 2;
    localparam int MAG_W    = ROT_W - 2;
    // The largest normalised magnitude lies in [2^(NORM_W-1), 2^NORM_W) unless all are zero.
    localparam int NORM_W   = 30;
    localparam int NORM_MSB = NORM_W - 1;
    localparam int MSB_W    = $clog2(MAG_W);
    localparam int SQ_W     = 2 * NORM_W + 2;
    localparam int LP_W     = NORM_W + 1 + LANE_W;
    localparam int DOT_W    = LP_W + 2;
    localparam int ROOT_W   = SQ_W / 2;
    localparam int NS       = SQ_W / 2;
    localparam int QB       = FRAC_BITS + 1;
    localparam int SHADE_W  = 15;
    localparam logic [SHADE_W-1:0] SHADE_CAP = SHADE_W'(1) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_X = 2'd0,
        CFG_ROT_Y = 2'd1,
        CFG_ROT_Z = 2'd2,
        CFG_LIGHT = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] ROT_X_RST = 48'd16384;
    localparam logic [CFG_W-1:0] ROT_Y_RST = 48'd1073741824;
    localparam logic [CFG_W-1:0] ROT_Z_RST = 48'd70368744177664;
    localparam logic [CFG_W-1:0] LIGHT_RST = 48'd70368744177664;

    typedef struct packed {
        logic signed [LANE_W-1:0] normal_x;
        logic signed [LANE_W-1:0] normal_y;
        logic signed [LANE_W-1:0] normal_z;
        logic                     last_in;
    } t_in;

    typedef struct packed {
        logic [SHADE_W-1:0] shade;
        logic               last_out;
    } t_out;

    // Front end to square root: sum of squares and light dot product.
    typedef struct packed {
        logic [SQ_W-1:0]         sq;
        logic signed [DOT_W-1:0] dot;
        logic                    last;
    } t_front;

    // Square root to divider: vector length and dot product.
    typedef struct packed {
        logic [ROOT_W-1:0]       len;
        logic signed [DOT_W-1:0] dot;
        logic                    last;
    } t_len;

    function automatic logic signed [LANE_W-1:0] lane(input logic [CFG_W-1:0] r,
                                                      input int idx);
        return $signed(r[LANE_W*idx +: LANE_W]);
    endfunction

endpackage

@@ sv/csvc_front.sv @@
`timescale 1ns / 1ps
// Front pipeline: rotation, magnitude, normalising shift, squares and light products.
// Depends on csvc_pkg.
module csvc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  csvc_pkg::t_in               i_data,
    input  logic [csvc_pkg::CFG_W-1:0]  i_rot_x,
    input  logic [csvc_pkg::CFG_W-1:0]  i_rot_y,
    input  logic [csvc_pkg::CFG_W-1:0]  i_rot_z,
    input  logic [csvc_pkg::CFG_W-1:0]  i_light,
    output logic                        o_valid,
    output csvc_pkg::t_front            o_data
);
    logic [4:0] r_v;
    logic [4:0] r_last;

    // stage 1
    logic signed [csvc_pkg::ROT_W-1:0] n_rot [3];
    logic signed [csvc_pkg::ROT_W-1:0] r_rot [3];
    // stage 2
    logic [csvc_pkg::MAG_W-1:0] n_mag [3];
    logic [csvc_pkg::MAG_W-1:0] r_mag [3];
    logic [2:0]                 r_neg;
    logic [csvc_pkg::MAG_W-1:0] n_mx;
    logic [csvc_pkg::MAG_W-1:0] r_mx;
    // stage 3
    logic [csvc_pkg::MSB_W-1:0]         msb;
    logic [csvc_pkg::MAG_W-1:0]         sh_mag [3];
    logic [csvc_pkg::NORM_W-1:0]        r_nm [3];
    logic signed [csvc_pkg::NORM_W:0]   r_c [3];
    // stage 4
    logic [2*csvc_pkg::NORM_W-1:0]      r_sq [3];
    logic signed [csvc_pkg::LP_W-1:0]   r_lp [3];
    // stage 5
    logic [csvc_pkg::SQ_W-1:0]          r_sum_sq;
    logic signed [csvc_pkg::DOT_W-1:0]  r_dot;

    always_comb begin
        logic [csvc_pkg::CFG_W-1:0] row;
        logic signed [2*csvc_pkg::LANE_W-1:0] p0, p1, p2;
        for (int i = 0; i < 3; i++) begin
            row = (i == 0) ? i_rot_x : ((i == 1) ? i_rot_y : i_rot_z);
            p0 = csvc_pkg::lane(row, 0) * i_data.normal_x;
            p1 = csvc_pkg::lane(row, 1) * i_data.normal_y;
            p2 = csvc_pkg::lane(row, 2) * i_data.normal_z;
            n_rot[i] = csvc_pkg::ROT_W'(p0) + csvc_pkg::ROT_W'(p1) + csvc_pkg::ROT_W'(p2);
        end
    end

    always_comb begin
        n_mx = '0;
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = r_rot[i][csvc_pkg::ROT_W-1] ? csvc_pkg::MAG_W'(-r_rot[i])
                                                   : csvc_pkg::MAG_W'(r_rot[i]);
            if (n_mag[i] > n_mx) begin
                n_mx = n_mag[i];
            end
        end
    end

    always_comb begin
        msb = '0;
        for (int b = 0; b < csvc_pkg::MAG_W; b++) begin
            if (r_mx[b]) begin
                msb = csvc_pkg::MSB_W'(b);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (msb >= csvc_pkg::MSB_W'(csvc_pkg::NORM_MSB)) begin
                sh_mag[i] = r_mag[i] >> (msb - csvc_pkg::MSB_W'(csvc_pkg::NORM_MSB));
            end else begin
                sh_mag[i] = r_mag[i] << (csvc_pkg::MSB_W'(csvc_pkg::NORM_MSB) - msb);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_last <= {r_last[3:0], i_data.last_in};
            r_mx   <= n_mx;
            for (int i = 0; i < 3; i++) begin
                r_rot[i] <= n_rot[i];
                r_mag[i] <= n_mag[i];
                r_neg[i] <= r_rot[i][csvc_pkg::ROT_W-1];
                r_nm[i]  <= sh_mag[i][csvc_pkg::NORM_W-1:0];
                r_c[i]   <= r_neg[i] ? -$signed({1'b0, sh_mag[i][csvc_pkg::NORM_W-1:0]})
                                     :  $signed({1'b0, sh_mag[i][csvc_pkg::NORM_W-1:0]});
                r_sq[i]  <= r_nm[i] * r_nm[i];
                r_lp[i]  <= csvc_pkg::LP_W'(r_c[i] * csvc_pkg::lane(i_light, i));
            end
            r_sum_sq <= csvc_pkg::SQ_W'(r_sq[0]) + csvc_pkg::SQ_W'(r_sq[1])
                      + csvc_pkg::SQ_W'(r_sq[2]);
            r_dot    <= csvc_pkg::DOT_W'(r_lp[0]) + csvc_pkg::DOT_W'(r_lp[1])
                      + csvc_pkg::DOT_W'(r_lp[2]);
        end
    end

    assign o_valid     = r_v[4];
    assign o_data.sq   = r_sum_sq;
    assign o_data.dot  = r_dot;
    assign o_data.last = r_last[4];

endmodule

@@ sv/csvc_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, dot product carried alongside.
// Depends on csvc_pkg.
module csvc_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  csvc_pkg::t_front  i_data,
    output logic              o_valid,
    output csvc_pkg::t_len    o_data
);
    localparam int N = csvc_pkg::NS;

    logic [csvc_pkg::SQ_W-1:0]          r_x    [N];
    logic [csvc_pkg::SQ_W-1:0]          r_res  [N];
    logic signed [csvc_pkg::DOT_W-1:0]  r_dot  [N];
    logic [N-1:0]                       r_last;
    logic [N-1:0]                       r_v;

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam int K = N - 1 - j;
        localparam logic [csvc_pkg::SQ_W-1:0] C_BIT = csvc_pkg::SQ_W'(1) << (2 * K);

        logic [csvc_pkg::SQ_W-1:0]         x_in;
        logic [csvc_pkg::SQ_W-1:0]         res_in;
        logic signed [csvc_pkg::DOT_W-1:0] dot_in;
        logic                              last_in;
        logic                              v_in;
        logic [csvc_pkg::SQ_W:0]           trial;

        if (j == 0) begin : g_first
            assign x_in    = i_data.sq;
            assign res_in  = '0;
            assign dot_in  = i_data.dot;
            assign last_in = i_data.last;
            assign v_in    = i_valid;
        end else begin : g_next
            assign x_in    = r_x[j-1];
            assign res_in  = r_res[j-1];
            assign dot_in  = r_dot[j-1];
            assign last_in = r_last[j-1];
            assign v_in    = r_v[j-1];
        end

        assign trial = {1'b0, res_in} + {1'b0, C_BIT};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, x_in} >= trial) begin
                    r_x[j]   <= x_in - trial[csvc_pkg::SQ_W-1:0];
                    r_res[j] <= (res_in >> 1) + C_BIT;
                end else begin
                    r_x[j]   <= x_in;
                    r_res[j] <= res_in >> 1;
                end
                r_dot[j]  <= dot_in;
                r_last[j] <= last_in;
            end
        end
    end

    assign o_valid     = r_v[N-1];
    assign o_data.len  = r_res[N-1][csvc_pkg::ROOT_W-1:0];
    assign o_data.dot  = r_dot[N-1];
    assign o_data.last = r_last[N-1];

endmodule

@@ sv/csvc_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider for dot / length with clamp, plus the output register.
// Depends on csvc_pkg.
module csvc_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  csvc_pkg::t_len   i_data,
    output logic             o_valid,
    output csvc_pkg::t_out   o_data
);
    localparam int N     = csvc_pkg::QB;
    localparam int REM_W = csvc_pkg::DOT_W - 1;

    // pre-stage: sign test and overflow check
    logic                         r0_v;
    logic                         r0_pos;
    logic                         r0_sat;
    logic                         r0_last;
    logic [REM_W-1:0]             r0_rem;
    logic [csvc_pkg::ROOT_W-1:0]  r0_len;

    logic [REM_W-1:0]             r_rem  [N];
    logic [csvc_pkg::ROOT_W-1:0]  r_len  [N];
    logic [N-1:0]                 r_q    [N];
    logic [N-1:0]                 r_pos;
    logic [N-1:0]                 r_sat;
    logic [N-1:0]                 r_last;
    logic [N-1:0]                 r_v;

    logic                         r_out_v;
    csvc_pkg::t_out               r_out;

    logic [REM_W-1:0] n_rem0;
    logic [REM_W-1:0] sat_den;

    assign n_rem0  = i_data.dot[REM_W-1:0];
    assign sat_den = REM_W'(i_data.len) << N;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_pos  <= (i_data.dot > 0);
            r0_sat  <= (n_rem0 >= sat_den);
            r0_rem  <= n_rem0;
            r0_len  <= i_data.len;
            r0_last <= i_data.last;
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam int K = N - 1 - j;

        logic [REM_W-1:0]            rem_in;
        logic [csvc_pkg::ROOT_W-1:0] len_in;
        logic [N-1:0]                q_in;
        logic                        pos_in;
        logic                        sat_in;
        logic                        last_in;
        logic                        v_in;
        logic [REM_W-1:0]            den;

        if (j == 0) begin : g_first
            assign rem_in  = r0_rem;
            assign len_in  = r0_len;
            assign q_in    = '0;
            assign pos_in  = r0_pos;
            assign sat_in  = r0_sat;
            assign last_in = r0_last;
            assign v_in    = r0_v;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign len_in  = r_len[j-1];
            assign q_in    = r_q[j-1];
            assign pos_in  = r_pos[j-1];
            assign sat_in  = r_sat[j-1];
            assign last_in = r_last[j-1];
            assign v_in    = r_v[j-1];
        end

        assign den = REM_W'(len_in) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= den) begin
                    r_rem[j] <= rem_in - den;
                    r_q[j]   <= q_in | (N'(1) << K);
                end else begin
                    r_rem[j] <= rem_in;
                    r_q[j]   <= q_in;
                end
                r_len[j]  <= len_in;
                r_pos[j]  <= pos_in;
                r_sat[j]  <= sat_in;
                r_last[j] <= last_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_pos[N-1]) begin
                r_out.shade <= '0;
            end else if (r_sat[N-1] || (r_q[N-1] > N'(csvc_pkg::SHADE_CAP))) begin
                r_out.shade <= csvc_pkg::SHADE_CAP;
            end else begin
                r_out.shade <= csvc_pkg::SHADE_W'(r_q[N-1]);
            end
            r_out.last_out <= r_last[N-1];
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

@@ sv/cel_shade_vertex_coordinate_core.sv @@
`timescale 1ns / 1ps
// Top level of the cel-shade vertex coordinate core: configuration registers and pipeline.
// Depends on csvc_pkg, csvc_front, csvc_sqrt and csvc_div.
//
// Takes one vertex normal (signed Q1.14 x, y, z plus a last-vertex flag) per transaction
// and returns one Lambert shade in unsigned Q1.14 (0 to 1.0, saturating) per transaction,
// in order. The block is a fully pipelined datapath: a new normal is accepted every cycle
// while the output side takes results. The stages are 5 front stages for rotation,
// normalising shift and products, 31 square-root stages at one root bit each, one clamp
// check stage, 15 divider stages at one quotient bit each and one output register.
// All stages advance together; when a result sits in the output register and is not
// taken, the whole pipe holds and input ready drops, so nothing is lost or repeated.
// Configuration registers (rotation rows and light direction) are written through a
// plain write port and must only change while the pipe is empty.
module cel_shade_vertex_coordinate_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // vertex input
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  csvc_pkg::t_in                   i_in_data,
    // shade output
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output csvc_pkg::t_out                  o_out_data,
    // configuration writes
    input  logic                            i_cfg_wr_en,
    input  logic [csvc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [csvc_pkg::CFG_W-1:0]      i_cfg_wdata
);
    logic [csvc_pkg::CFG_W-1:0] r_rot_x;
    logic [csvc_pkg::CFG_W-1:0] r_rot_y;
    logic [csvc_pkg::CFG_W-1:0] r_rot_z;
    logic [csvc_pkg::CFG_W-1:0] r_light;

    logic              adv;
    logic              front_v;
    csvc_pkg::t_front  front_d;
    logic              len_v;
    csvc_pkg::t_len    len_d;

    // Advance every stage unless a finished result is waiting to be taken.
    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // Configuration registers: write on enable; each of the four indexes selects one register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_x <= csvc_pkg::ROT_X_RST;
            r_rot_y <= csvc_pkg::ROT_Y_RST;
            r_rot_z <= csvc_pkg::ROT_Z_RST;
            r_light <= csvc_pkg::LIGHT_RST;
        end else if (i_cfg_wr_en) begin
            case (csvc_pkg::t_cfg_idx'(i_cfg_idx))
                csvc_pkg::CFG_ROT_X: r_rot_x <= i_cfg_wdata;
                csvc_pkg::CFG_ROT_Y: r_rot_y <= i_cfg_wdata;
                csvc_pkg::CFG_ROT_Z: r_rot_z <= i_cfg_wdata;
                csvc_pkg::CFG_LIGHT: r_light <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Rotate, normalise, square and take the light dot product.
    csvc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_rot_x (r_rot_x),
        .i_rot_y (r_rot_y),
        .i_rot_z (r_rot_z),
        .i_light (r_light),
        .o_valid (front_v),
        .o_data  (front_d)
    );

    // Vector length from the sum of squares.
    csvc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (front_v),
        .i_data  (front_d),
        .o_valid (len_v),
        .o_data  (len_d)
    );

    // Shade = dot / length, clamped to [0, 1.0]; holds the output register.
    csvc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (len_v),
        .i_data  (len_d),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

@@ sv/csvc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the cel-shade vertex coordinate core, and the bind that attaches them.
// Depends on csvc_pkg and cel_shade_vertex_coordinate_core.
module csvc_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            o_in_ready,
    input  logic            o_out_valid,
    input  logic            i_out_ready,
    input  csvc_pkg::t_out  o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_shade_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.shade <= csvc_pkg::SHADE_CAP))
        else $error("shade above 1.0");

    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind cel_shade_vertex_coordinate_core csvc_checker u_csvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
